// ===== rtl/clr_pkg.sv =====
// Shared types and constants for the clipped line rasterizer.
// No dependencies; imported by every module of the block.
package clr_pkg;

   localparam int SCREEN_WIDTH  = 64;
   localparam int SCREEN_HEIGHT = 64;
   localparam int FRAC_BITS     = 24;
   localparam int PALETTE_SIZE  = 8;
   localparam int MAX_RESULTS   = 64;

   localparam int IN_W      = 16;                      // endpoint field width
   localparam int CLIP_W    = 6;                       // clip register width
   localparam int PIX_W     = CLIP_W;                  // clipped coordinate width
   localparam int COORD_W   = IN_W + 1;                // working coordinate / delta
   localparam int EDGE_W    = COORD_W + 1;             // edge numerator / denominator
   localparam int MUL_W     = EDGE_W;
   localparam int PROD_W    = 2 * MUL_W;
   localparam int DIVD_W    = PROD_W - 1;              // dividend magnitude
   localparam int DIVR_W    = IN_W;                    // divisor width
   localparam int DIV_CNT_W = $clog2(DIVD_W + 1);
   localparam int ADDR_W    = 12;
   localparam int COLOR_W   = 8;
   localparam int PAL_W     = PALETTE_SIZE * COLOR_W;
   localparam int PAL_IDX_W = $clog2(PALETTE_SIZE);
   localparam int RES_CNT_W = $clog2(MAX_RESULTS);
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = PAL_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CLIP_LEFT   = 3'd0,
      CSR_CLIP_RIGHT  = 3'd1,
      CSR_CLIP_TOP    = 3'd2,
      CSR_CLIP_BOTTOM = 3'd3,
      CSR_PALETTE     = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      EDGE_LEFT, EDGE_RIGHT, EDGE_TOP, EDGE_BOTTOM
   } edge_type;

   typedef enum logic [1:0] {
      MUL_EDGE_1, MUL_EDGE_2, MUL_CLIP_1, MUL_CLIP_2
   } mul_sel_type;

   typedef enum logic [1:0] {
      TGT_X2, TGT_Y2, TGT_X1, TGT_Y1
   } tgt_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_CHECK, ST_EDGE, ST_MUL_A, ST_MUL_B, ST_TEST, ST_MUL_C,
      ST_MUL_D, ST_UPDATE, ST_CLIP_START, ST_CLIP_MUL1, ST_CLIP_MUL2,
      ST_CLIP_DIV, ST_CLIP_WAIT, ST_SETUP, ST_SLOPE_DIV, ST_SLOPE_WAIT,
      ST_DRAW, ST_REJECT
   } state_type;

   typedef struct packed {
      logic signed [IN_W-1:0] start_x;
      logic signed [IN_W-1:0] start_y;
      logic signed [IN_W-1:0] end_x;
      logic signed [IN_W-1:0] end_y;
      logic                   mode;
      logic [COLOR_W-1:0]     color;
   } req_payload_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  pixel_address;
      logic [COLOR_W-1:0] pixel_color;
      logic               drawn;
      logic               last;
   } rsp_payload_type;

   typedef struct packed {
      logic        load;
      logic        edge_next;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        pair;
      logic        update;
      tgt_type     tgt;
      logic        div_start;
      logic        div_slope;
      logic        clip_write;
      logic        setup;
      logic        slope_write;
      logic        draw_step;
      logic        emit_reject;
   } cmd_type;

   typedef struct packed {
      logic outside_any;
      logic degenerate;
      logic den_zero;
      logic num_pos;
      logic edge_last;
      logic cond;
      logic leave_clip;
      logic enter_clip;
      logic div_done;
      logic slope_zero;
      logic out_free;
      logic draw_last;
   } status_type;

endpackage

// ===== rtl/clipped_line_rasterizer.sv =====
// Top level of the clipped line rasterizer: controller plus datapath.
// Depends on clr_pkg, clr_ctrl, clr_datapath (and clr_div below it).
//
// Takes one segment per req transfer and returns its pixel writes on rsp, in
// order along the major axis, with last set on the final one; a segment
// rejected by clipping yields a single result with drawn low. A new segment
// is taken only when the previous one has issued its last result into the
// output register. Segments fully inside the clip rectangle start drawing
// after setup and, unless the line is a single pixel, the slope division;
// then one pixel per cycle while rsp is ready. Clipped segments first run
// edge tests on the shared multiplier, then one division per clipped
// coordinate (up to four) on the serial one-bit-per-cycle divider.
// Clip and palette registers must be written only while idle; the block
// itself does not enforce this.
module clipped_line_rasterizer
   import clr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_data,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   cmd_type    cmd;
   status_type status;

   clr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   clr_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_data         (req_data),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

// ===== rtl/clr_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on clr_pkg for widths.
module clr_div
   import clr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIVD_W-1:0] dividend,
   input  logic [DIVR_W-1:0] divisor,
   output logic [DIVD_W-1:0] quotient,
   output logic              done
);

   logic [DIVD_W-1:0]    quo_ff;
   logic [DIVR_W-1:0]    rem_ff;
   logic [DIVR_W-1:0]    dvs_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 done_ff;

   logic [DIVR_W:0] acc;
   logic [DIVR_W:0] diff;

   assign acc  = {rem_ff, quo_ff[DIVD_W-1]};
   assign diff = acc - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else if (start) begin
         cnt_ff  <= DIV_CNT_W'(DIVD_W);
         done_ff <= 1'b0;
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (cnt_ff != '0) begin
         if (!diff[DIVR_W]) begin
            rem_ff <= diff[DIVR_W-1:0];
            quo_ff <= {quo_ff[DIVD_W-2:0], 1'b1};
         end else begin
            rem_ff <= acc[DIVR_W-1:0];
            quo_ff <= {quo_ff[DIVD_W-2:0], 1'b0};
         end
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// ===== rtl/clr_ctrl.sv =====
// Sequencer for clipping, slope setup and pixel walk.
// Depends on clr_pkg; drives the datapath through cmd_type.
module clr_ctrl
   import clr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   tgt_type   tgt_ff, tgt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tgt_ff   <= TGT_X2;
      end else begin
         state_ff <= state_in;
         tgt_ff   <= tgt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      tgt_in   = tgt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!status.outside_any)    state_in = ST_SETUP;
            else if (status.degenerate) state_in = ST_REJECT;
            else                        state_in = ST_EDGE;
         end
         ST_EDGE: begin
            if (status.den_zero) begin
               if (status.num_pos)        state_in = ST_REJECT;
               else if (status.edge_last) state_in = ST_CLIP_START;
            end else begin
               state_in = ST_MUL_A;
            end
         end
         ST_MUL_A: state_in = ST_MUL_B;
         ST_MUL_B: state_in = ST_TEST;
         ST_TEST:  state_in = status.cond ? ST_REJECT : ST_MUL_C;
         ST_MUL_C: state_in = ST_MUL_D;
         ST_MUL_D: state_in = ST_UPDATE;
         ST_UPDATE: state_in = status.edge_last ? ST_CLIP_START : ST_EDGE;
         ST_CLIP_START: begin
            if (status.leave_clip) begin
               tgt_in   = TGT_X2;
               state_in = ST_CLIP_MUL1;
            end else if (status.enter_clip) begin
               tgt_in   = TGT_X1;
               state_in = ST_CLIP_MUL1;
            end else begin
               state_in = ST_SETUP;
            end
         end
         ST_CLIP_MUL1: state_in = ST_CLIP_MUL2;
         ST_CLIP_MUL2: state_in = ST_CLIP_DIV;
         ST_CLIP_DIV:  state_in = ST_CLIP_WAIT;
         ST_CLIP_WAIT: begin
            if (status.div_done) begin
               case (tgt_ff)
                  TGT_X2: begin
                     tgt_in   = TGT_Y2;
                     state_in = ST_CLIP_MUL1;
                  end
                  TGT_Y2: begin
                     if (status.enter_clip) begin
                        tgt_in   = TGT_X1;
                        state_in = ST_CLIP_MUL1;
                     end else begin
                        state_in = ST_SETUP;
                     end
                  end
                  TGT_X1: begin
                     tgt_in   = TGT_Y1;
                     state_in = ST_CLIP_MUL1;
                  end
                  default: state_in = ST_SETUP;
               endcase
            end
         end
         ST_SETUP: state_in = status.slope_zero ? ST_DRAW : ST_SLOPE_DIV;
         ST_SLOPE_DIV: state_in = ST_SLOPE_WAIT;
         ST_SLOPE_WAIT: begin
            if (status.div_done) state_in = ST_DRAW;
         end
         ST_DRAW: begin
            if (status.out_free && status.draw_last) state_in = ST_IDLE;
         end
         ST_REJECT: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd         = '0;
      cmd.tgt     = tgt_ff;
      cmd.mul_sel = MUL_EDGE_1;
      req_ready   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_EDGE: cmd.edge_next = status.den_zero && !status.num_pos;
         ST_MUL_A: cmd.mul_en = 1'b1;
         ST_MUL_B: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_EDGE_2;
         end
         ST_MUL_C: begin
            cmd.mul_en = 1'b1;
            cmd.pair   = 1'b1;
         end
         ST_MUL_D: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_EDGE_2;
            cmd.pair    = 1'b1;
         end
         ST_UPDATE: begin
            cmd.pair      = 1'b1;
            cmd.update    = 1'b1;
            cmd.edge_next = 1'b1;
         end
         ST_CLIP_MUL1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_CLIP_1;
         end
         ST_CLIP_MUL2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_CLIP_2;
         end
         ST_CLIP_DIV:   cmd.div_start  = 1'b1;
         ST_CLIP_WAIT:  cmd.clip_write = status.div_done;
         ST_SETUP:      cmd.setup      = 1'b1;
         ST_SLOPE_DIV: begin
            cmd.div_start = 1'b1;
            cmd.div_slope = 1'b1;
         end
         ST_SLOPE_WAIT: cmd.slope_write = status.div_done;
         ST_DRAW:       cmd.draw_step   = status.out_free;
         ST_REJECT:     cmd.emit_reject = status.out_free;
         default: ;
      endcase
   end

endmodule

// ===== rtl/clr_datapath.sv =====
// Datapath: clip registers, edge tests, shared multiplier and divider, DDA
// walker and the result register. Depends on clr_pkg and clr_div.
module clr_datapath
   import clr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  req_payload_type       req_data,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output rsp_payload_type       rsp_data,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  cmd_type               cmd,
   output status_type            status
);

   // configuration
   logic [CLIP_W-1:0] clip_left_ff, clip_right_ff, clip_top_ff, clip_bottom_ff;
   logic [PAL_W-1:0]  palette_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_left_ff   <= '0;
         clip_right_ff  <= '1;
         clip_top_ff    <= '0;
         clip_bottom_ff <= '1;
         palette_ff     <= '0;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_CLIP_LEFT:   clip_left_ff   <= csr_write_data[CLIP_W-1:0];
            CSR_CLIP_RIGHT:  clip_right_ff  <= csr_write_data[CLIP_W-1:0];
            CSR_CLIP_TOP:    clip_top_ff    <= csr_write_data[CLIP_W-1:0];
            CSR_CLIP_BOTTOM: clip_bottom_ff <= csr_write_data[CLIP_W-1:0];
            CSR_PALETTE:     palette_ff     <= csr_write_data;
            default: ;
         endcase
      end
   end

   // line registers
   logic signed [COORD_W-1:0] x1_ff, y1_ff, x2_ff, y2_ff, dx_ff, dy_ff;
   logic                      mode_ff;
   logic [COLOR_W-1:0]        color_ff;
   edge_type                  edge_ff;
   logic signed [EDGE_W-1:0]  en_ff, ln_ff;
   logic [DIVR_W-1:0]         ed_ff, ld_ff;
   logic signed [PROD_W-1:0]  prod_ff, prev_ff;
   logic                      neg_ff;

   // edge terms
   logic signed [EDGE_W-1:0] x1_e, y1_e, dx_e, dy_e, num, den, tn, td_full;
   logic signed [EDGE_W-1:0] left_e, right_e, top_e, bottom_e;
   logic                     den_neg, den_zero, den_pos, sel_leave;

   assign x1_e     = {x1_ff[COORD_W-1], x1_ff};
   assign y1_e     = {y1_ff[COORD_W-1], y1_ff};
   assign dx_e     = {dx_ff[COORD_W-1], dx_ff};
   assign dy_e     = {dy_ff[COORD_W-1], dy_ff};
   assign left_e   = {{(EDGE_W-CLIP_W){1'b0}}, clip_left_ff};
   assign right_e  = {{(EDGE_W-CLIP_W){1'b0}}, clip_right_ff};
   assign top_e    = {{(EDGE_W-CLIP_W){1'b0}}, clip_top_ff};
   assign bottom_e = {{(EDGE_W-CLIP_W){1'b0}}, clip_bottom_ff};

   always_comb begin
      case (edge_ff)
         EDGE_LEFT: begin
            num = left_e - x1_e;
            den = dx_e;
         end
         EDGE_RIGHT: begin
            num = x1_e - right_e;
            den = -dx_e;
         end
         EDGE_TOP: begin
            num = top_e - y1_e;
            den = dy_e;
         end
         default: begin
            num = y1_e - bottom_e;
            den = -dy_e;
         end
      endcase
   end

   assign den_neg   = den[EDGE_W-1];
   assign den_zero  = (den == '0);
   assign den_pos   = !den_neg && !den_zero;
   assign tn        = den_neg ? -num : num;
   assign td_full   = den_neg ? -den : den;
   // pair 0 tests rejection, pair 1 tests the update; the bound used flips with den sign
   assign sel_leave = den_pos ^ cmd.pair;

   // shared multiplier
   logic                      leave_tgt, tgt_y;
   logic signed [COORD_W-1:0] coord_sel, delta_sel;
   logic signed [MUL_W-1:0]   mul_a, mul_b;
   logic signed [PROD_W-1:0]  prod;

   assign leave_tgt = (cmd.tgt == TGT_X2) || (cmd.tgt == TGT_Y2);
   assign tgt_y     = (cmd.tgt == TGT_Y2) || (cmd.tgt == TGT_Y1);
   assign coord_sel = tgt_y ? y1_ff : x1_ff;
   assign delta_sel = tgt_y ? dy_ff : dx_ff;

   always_comb begin
      case (cmd.mul_sel)
         MUL_EDGE_1: begin
            mul_a = tn;
            mul_b = {2'b00, (sel_leave ? ld_ff : ed_ff)};
         end
         MUL_EDGE_2: begin
            mul_a = sel_leave ? ln_ff : en_ff;
            mul_b = {2'b00, td_full[DIVR_W-1:0]};
         end
         MUL_CLIP_1: begin
            mul_a = {coord_sel[COORD_W-1], coord_sel};
            mul_b = {2'b00, ld_ff};
         end
         default: begin
            mul_a = leave_tgt ? ln_ff : en_ff;
            mul_b = {delta_sel[COORD_W-1], delta_sel};
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   // divider feed
   logic signed [PROD_W-1:0]  clip_sum, clip_mag;
   logic                      clip_neg;
   logic [DIVD_W-1:0]         div_dividend, div_quo;
   logic [DIVR_W-1:0]         div_divisor;
   logic                      div_done;
   logic signed [PROD_W-1:0]  q_full;
   logic signed [COORD_W-1:0] q_coord;

   logic [PIX_W-1:0] maj_delta_ff, min_delta_ff;

   assign clip_sum = leave_tgt ? (prev_ff + prod_ff) : prod_ff;
   assign clip_neg = clip_sum[PROD_W-1];
   assign clip_mag = clip_neg ? -clip_sum : clip_sum;

   assign div_dividend = cmd.div_slope
      ? {{(DIVD_W-PIX_W-FRAC_BITS){1'b0}}, min_delta_ff, {FRAC_BITS{1'b0}}}
      : clip_mag[DIVD_W-1:0];
   assign div_divisor = cmd.div_slope ? {{(DIVR_W-PIX_W){1'b0}}, maj_delta_ff}
                                      : (leave_tgt ? ld_ff : ed_ff);

   clr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quo),
      .done     (div_done)
   );

   // quotient truncates toward zero: divide magnitudes, then restore sign
   assign q_full  = neg_ff ? -{1'b0, div_quo} : {1'b0, div_quo};
   assign q_coord = q_full[COORD_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x1_ff    <= {req_data.start_x[IN_W-1], req_data.start_x};
         y1_ff    <= {req_data.start_y[IN_W-1], req_data.start_y};
         x2_ff    <= {req_data.end_x[IN_W-1], req_data.end_x};
         y2_ff    <= {req_data.end_y[IN_W-1], req_data.end_y};
         dx_ff    <= {req_data.end_x[IN_W-1], req_data.end_x}
                   - {req_data.start_x[IN_W-1], req_data.start_x};
         dy_ff    <= {req_data.end_y[IN_W-1], req_data.end_y}
                   - {req_data.start_y[IN_W-1], req_data.start_y};
         mode_ff  <= req_data.mode;
         color_ff <= req_data.color;
         en_ff    <= '0;
         ed_ff    <= DIVR_W'(1);
         ln_ff    <= EDGE_W'(1);
         ld_ff    <= DIVR_W'(1);
      end else begin
         if (cmd.update && status.cond) begin
            if (sel_leave) begin
               ln_ff <= tn;
               ld_ff <= td_full[DIVR_W-1:0];
            end else begin
               en_ff <= tn;
               ed_ff <= td_full[DIVR_W-1:0];
            end
         end
         if (cmd.clip_write) begin
            case (cmd.tgt)
               TGT_X2:  x2_ff <= q_coord;
               TGT_Y2:  y2_ff <= q_coord;
               TGT_X1:  x1_ff <= x1_ff + q_coord;
               default: y1_ff <= y1_ff + q_coord;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         edge_ff <= EDGE_LEFT;
      end else if (cmd.edge_next) begin
         case (edge_ff)
            EDGE_LEFT:  edge_ff <= EDGE_RIGHT;
            EDGE_RIGHT: edge_ff <= EDGE_TOP;
            default:    edge_ff <= EDGE_BOTTOM;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= prod;
         prev_ff <= prod_ff;
      end
      if (cmd.div_start) begin
         neg_ff <= !cmd.div_slope && clip_neg;
      end
   end

   // draw setup on clipped coordinates, which lie inside the rectangle
   logic [PIX_W-1:0] sx1, sy1, sx2, sy2, h, v, ax, ay, bx, by;
   logic             x_major, do_swap;

   assign sx1 = x1_ff[PIX_W-1:0];
   assign sy1 = y1_ff[PIX_W-1:0];
   assign sx2 = x2_ff[PIX_W-1:0];
   assign sy2 = y2_ff[PIX_W-1:0];
   assign h   = (sx2 > sx1) ? sx2 - sx1 : sx1 - sx2;
   assign v   = (sy2 > sy1) ? sy2 - sy1 : sy1 - sy2;
   assign x_major = h >= v;
   assign do_swap = x_major ? (sx1 > sx2) : (sy1 > sy2);
   assign ax = do_swap ? sx2 : sx1;
   assign ay = do_swap ? sy2 : sy1;
   assign bx = do_swap ? sx1 : sx2;
   assign by = do_swap ? sy1 : sy2;

   logic                  x_major_ff, dir_neg_ff;
   logic [PIX_W-1:0]      maj_ff, min_ff, rem_ff;
   logic [RES_CNT_W-1:0]  pix_cnt_ff;
   logic [FRAC_BITS-1:0]  ds_ff;
   logic [FRAC_BITS:0]    m_ff, ds_sum;
   logic [PIX_W-1:0]      px, py;
   logic [PAL_IDX_W-1:0]  pal_idx;
   logic [ADDR_W-1:0]     pix_addr;
   logic [COLOR_W-1:0]    pix_color;
   logic                  draw_last;

   assign ds_sum    = {1'b0, ds_ff} + m_ff;
   assign px        = x_major_ff ? maj_ff : min_ff;
   assign py        = x_major_ff ? min_ff : maj_ff;
   assign pal_idx   = pix_cnt_ff[PAL_IDX_W-1:0];
   assign pix_addr  = ADDR_W'(py) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(px);
   assign pix_color = mode_ff ? palette_ff[{pal_idx, 3'b000} +: COLOR_W] : color_ff;
   assign draw_last = (rem_ff == '0) || (pix_cnt_ff == RES_CNT_W'(MAX_RESULTS - 1));

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         x_major_ff   <= x_major;
         maj_ff       <= x_major ? ax : ay;
         min_ff       <= x_major ? ay : ax;
         dir_neg_ff   <= x_major ? (ay > by) : (ax > bx);
         rem_ff       <= x_major ? h : v;
         maj_delta_ff <= x_major ? h : v;
         min_delta_ff <= x_major ? v : h;
         pix_cnt_ff   <= '0;
         ds_ff        <= FRAC_BITS'((1 << (FRAC_BITS - 1)) - 1);
         m_ff         <= '0;
      end else if (cmd.slope_write) begin
         m_ff <= div_quo[FRAC_BITS:0];
      end else if (cmd.draw_step) begin
         pix_cnt_ff <= pix_cnt_ff + 1'b1;
         rem_ff     <= rem_ff - 1'b1;
         ds_ff      <= ds_sum[FRAC_BITS-1:0];
         maj_ff     <= maj_ff + 1'b1;
         if (ds_sum[FRAC_BITS]) begin
            min_ff <= dir_neg_ff ? min_ff - 1'b1 : min_ff + 1'b1;
         end
      end
   end

   // result register
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff;
   logic            out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.draw_step || cmd.emit_reject) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.draw_step) begin
         rsp_data_ff.pixel_address <= pix_addr;
         rsp_data_ff.pixel_color   <= pix_color;
         rsp_data_ff.drawn         <= 1'b1;
         rsp_data_ff.last          <= draw_last;
      end else if (cmd.emit_reject) begin
         rsp_data_ff.pixel_address <= '0;
         rsp_data_ff.pixel_color   <= '0;
         rsp_data_ff.drawn         <= 1'b0;
         rsp_data_ff.last          <= 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // status
   logic out1, out2;

   function automatic logic pt_outside(input logic signed [EDGE_W-1:0] x,
                                       input logic signed [EDGE_W-1:0] y,
                                       input logic signed [EDGE_W-1:0] l,
                                       input logic signed [EDGE_W-1:0] r,
                                       input logic signed [EDGE_W-1:0] t,
                                       input logic signed [EDGE_W-1:0] b);
      return (x < l) || (x > r) || (y < t) || (y > b);
   endfunction

   assign out1 = pt_outside(x1_e, y1_e, left_e, right_e, top_e, bottom_e);
   assign out2 = pt_outside({x2_ff[COORD_W-1], x2_ff}, {y2_ff[COORD_W-1], y2_ff},
                            left_e, right_e, top_e, bottom_e);

   always_comb begin
      status             = '0;
      status.outside_any = out1 || out2;
      status.degenerate  = (x1_ff == x2_ff) && (y1_ff == y2_ff);
      status.den_zero    = den_zero;
      status.num_pos     = !num[EDGE_W-1] && (num != '0);
      status.edge_last   = (edge_ff == EDGE_BOTTOM);
      status.cond        = den_pos ? (prev_ff > prod_ff) : (prev_ff < prod_ff);
      status.leave_clip  = ln_ff < $signed({2'b00, ld_ff});
      status.enter_clip  = en_ff > $signed(EDGE_W'(0));
      status.div_done    = div_done;
      status.slope_zero  = (h == '0) && (v == '0);
      status.out_free    = out_free;
      status.draw_last   = draw_last;
   end

endmodule

// ===== rtl/clr_checker.sv =====
// Port-level checks for the clipped line rasterizer, bound to the top level.
// Depends on clr_pkg.
module clr_checker
   import clr_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_data
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("outputs not idle after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_reject_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.drawn |->
         rsp_data.last && (rsp_data.pixel_address == '0) && (rsp_data.pixel_color == '0))
      else $error("malformed rejection result");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("new segment taken while one is in flight");

endmodule

bind clipped_line_rasterizer clr_checker u_clr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== dv/clipped_line_rasterizer_tb.sv =====
// Self-checking testbench for clipped_line_rasterizer: segments in, pixel writes out.
// Depends on clr_pkg and the RTL top; predicts each pixel write and compares in order.
`timescale 1ns / 1ps

module clipped_line_rasterizer_tb;
   import clr_pkg::*;

   localparam int CYCLE_LIMIT = 1500000;
   localparam int DRAIN_CYCLES = 400;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_payload_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_payload_type rsp_data;
   logic csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   clipped_line_rasterizer dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // shadow copy of the clip window and palette
   int unsigned win_left, win_right, win_top, win_bottom;
   logic [63:0] palette;

   req_payload_type segment_queue[$];
   rsp_payload_type pixel_queue[$];
   int mismatches;
   int segments_sent;
   int segments_offered;
   int pixels_seen;
   int rejects_seen;
   int cycle_count;
   int rsp_hold;          // long receiver hold-off, in cycles
   bit stall_request;
   bit stall_done;
   bit feeding;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout at cycle %0d", cycle_count);
         $display("tb: failure");
         $finish;
      end
   end

   function automatic bit is_outside(longint x, longint y);
      return x < win_left || x > win_right || y < win_top || y > win_bottom;
   endfunction

   // one boundary test of the parametric clip; entry en/ed, leave ln/ld
   function automatic bit clip_edge(longint num, longint den, inout longint en,
                                    inout longint ed, inout longint ln,
                                    inout longint ld);
      longint tn, td;
      if (den == 0) return num <= 0;
      tn = den < 0 ? -num : num;
      td = den < 0 ? -den : den;
      if (den > 0) begin
         if (tn * ld > ln * td) return 0;
         if (tn * ed > en * td) begin
            en = tn;
            ed = td;
         end
      end else begin
         if (tn * ed < en * td) return 0;
         if (tn * ld < ln * td) begin
            ln = tn;
            ld = td;
         end
      end
      return 1;
   endfunction

   task automatic predict_pixels(input req_payload_type s);
      longint x1, y1, x2, y2, dx, dy, en, ed, ln, ld, t;
      longint h, v, steps, n;
      longint unsigned slope, acc;
      int x, y, dir, pal_idx;
      bit ok, x_major;
      rsp_payload_type r;
      x1 = s.start_x;
      y1 = s.start_y;
      x2 = s.end_x;
      y2 = s.end_y;
      if (is_outside(x1, y1) || is_outside(x2, y2)) begin
         dx = x2 - x1;
         dy = y2 - y1;
         en = 0; ed = 1; ln = 1; ld = 1;
         ok = !(x1 == x2 && y1 == y2);
         ok = ok && clip_edge(longint'(win_left) - x1, dx, en, ed, ln, ld);
         ok = ok && clip_edge(x1 - longint'(win_right), -dx, en, ed, ln, ld);
         ok = ok && clip_edge(longint'(win_top) - y1, dy, en, ed, ln, ld);
         ok = ok && clip_edge(y1 - longint'(win_bottom), -dy, en, ed, ln, ld);
         if (!ok) begin
            r = '0;
            r.last = 1'b1;
            pixel_queue.push_back(r);
            return;
         end
         // SV division truncates toward zero, like the hardware
         if (ln < ld) begin
            x2 = (x1 * ld + ln * dx) / ld;
            y2 = (y1 * ld + ln * dy) / ld;
         end
         if (en > 0) begin
            x1 = x1 + (en * dx) / ed;
            y1 = y1 + (en * dy) / ed;
         end
      end
      h = (x2 > x1 ? x2 - x1 : x1 - x2) & 16'hFFFF;
      v = (y2 > y1 ? y2 - y1 : y1 - y2) & 16'hFFFF;
      x_major = h >= v;
      if (x_major ? (x1 > x2) : (y1 > y2)) begin
         t = x1; x1 = x2; x2 = t;
         t = y1; y1 = y2; y2 = t;
      end
      if (x_major) begin
         slope = h != 0 ? ((longint'(v) << FRAC_BITS) / h) : 0;
         steps = h;
         dir = (y1 > y2) ? -1 : 1;
      end else begin
         slope = (longint'(h) << FRAC_BITS) / v;
         steps = v;
         dir = (x1 > x2) ? -1 : 1;
      end
      n = steps + 1;
      if (n > MAX_RESULTS) n = MAX_RESULTS;
      x = int'(x1);
      y = int'(y1);
      acc = (64'd1 << (FRAC_BITS - 1)) - 1;
      pal_idx = 0;
      for (int i = 0; i < n; i++) begin
         r.pixel_address = ADDR_W'(y * SCREEN_WIDTH + x);
         r.pixel_color = s.mode ? palette[8*pal_idx +: 8] : s.color;
         r.drawn = 1'b1;
         r.last = (i + 1 == n);
         pixel_queue.push_back(r);
         pal_idx = (pal_idx + 1) % PALETTE_SIZE;
         acc = acc + (slope & 32'hFFFFFFFF);
         if (x_major) begin
            x++;
            if (acc >> FRAC_BITS) y += dir;
         end else begin
            y++;
            if (acc >> FRAC_BITS) x += dir;
         end
         acc = acc & ((64'd1 << FRAC_BITS) - 1);
      end
   endtask

   // driver: one segment per transfer, random gap before each;
   // an offer is held until the accept count catches up with it
   int send_gap;
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= $urandom_range(0, 9);
      end else if (req_valid && segments_sent != segments_offered) begin
         // hold payload until the transfer
      end else if (send_gap > 0 || segment_queue.size() == 0 || !feeding) begin
         req_valid <= 1'b0;
         if (send_gap > 0) send_gap <= send_gap - 1;
      end else begin
         req_data <= segment_queue.pop_front();
         req_valid <= 1'b1;
         segments_offered <= segments_offered + 1;
         if ($urandom_range(0, 3) == 0) send_gap <= 0;
         else send_gap <= $urandom_range(0, 9);
      end
   end

   // predict as each transfer completes
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         predict_pixels(req_data);
         segments_sent <= segments_sent + 1;
      end
   end

   // long receiver hold-off, started once on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_hold <= 0;
         stall_done <= 1'b0;
      end else if (stall_request && !stall_done) begin
         rsp_hold <= 300;
         stall_done <= 1'b1;
      end else if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
      end
   end

   // receiver stall pattern
   int recv_gap;
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap <= $urandom_range(0, 9);
      end else if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
      end else if (recv_gap > 0) begin
         rsp_ready <= 1'b0;
         recv_gap <= recv_gap - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (rsp_valid) recv_gap <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 9) : 0;
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (rsp_data.drawn) pixels_seen <= pixels_seen + 1;
         else rejects_seen <= rejects_seen + 1;
         if (pixel_queue.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
               $display("unexpected transfer: %p", rsp_data);
         end else begin
            want = pixel_queue.pop_front();
            if (want !== rsp_data) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("mismatch: expected addr %0d color %h drawn %b last %b, got addr %0d color %h drawn %b last %b",
                     want.pixel_address, want.pixel_color, want.drawn, want.last,
                     rsp_data.pixel_address, rsp_data.pixel_color, rsp_data.drawn,
                     rsp_data.last);
            end
         end
      end
   end

   task automatic csr_write(input csr_index_type idx, input logic [63:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      case (idx)
         CSR_CLIP_LEFT:   win_left = 32'(value[5:0]);
         CSR_CLIP_RIGHT:  win_right = 32'(value[5:0]);
         CSR_CLIP_TOP:    win_top = 32'(value[5:0]);
         CSR_CLIP_BOTTOM: win_bottom = 32'(value[5:0]);
         default:         palette = value;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_window(input int l, input int r, input int t, input int b);
      csr_write(CSR_CLIP_LEFT, 64'(l));
      csr_write(CSR_CLIP_RIGHT, 64'(r));
      csr_write(CSR_CLIP_TOP, 64'(t));
      csr_write(CSR_CLIP_BOTTOM, 64'(b));
   endtask

   task automatic add_segment(input int x1, input int y1, input int x2, input int y2,
                              input bit mode, input logic [7:0] color);
      req_payload_type s;
      s.start_x = 16'(x1); s.start_y = 16'(y1); s.end_x = 16'(x2); s.end_y = 16'(y2);
      s.mode = mode; s.color = color;
      segment_queue.push_back(s);
   endtask

   // wait until everything sent has come back, then let the block settle
   task automatic drain;
      while (segment_queue.size() > 0 || req_valid || pixel_queue.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic int coord_near(input int lo, input int hi);
      case ($urandom_range(0, 9))
         0:       return int'($signed(16'($urandom)));
         1:       return $urandom_range(0, 1) ? 32767 : -32768;
         2, 3:    return int'($urandom_range(0, 200)) - 100;
         default: return int'($urandom_range(0, hi - lo + 16)) + lo - 8;
      endcase
   endfunction

   task automatic random_segments(input int count);
      int l, r;
      for (int i = 0; i < count; i++) begin
         l = win_left < win_right ? win_left : win_right;
         r = win_left < win_right ? win_right : win_left;
         add_segment(coord_near(l, r), coord_near(win_top, win_bottom),
                     coord_near(l, r), coord_near(win_top, win_bottom),
                     $urandom_range(0, 1), $urandom_range(0, 255));
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      win_left = 0; win_right = 63; win_top = 0; win_bottom = 63;
      palette = '0;
      mismatches = 0; segments_sent = 0; segments_offered = 0;
      pixels_seen = 0; rejects_seen = 0;
      cycle_count = 0; stall_request = 1'b0; feeding = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset window, then a random palette
      add_segment(0, 0, 63, 63, 0, 8'hFF);
      add_segment(5, 5, 5, 5, 1, 8'h00);            // single pixel
      add_segment(63, 0, 0, 63, 1, 8'h12);
      add_segment(-32768, -32768, 32767, 32767, 0, 8'hA5);
      add_segment(32767, 10, -32768, 20, 1, 8'h5A);
      add_segment(100, 100, 100, 100, 0, 8'h3C);    // degenerate outside point
      add_segment(-5, -5, -10, 70, 0, 8'h77);       // fully rejected
      add_segment(10, -20, 12, 90, 1, 8'h01);
      drain();
      csr_write(CSR_PALETTE, {$urandom, $urandom});
      add_segment(0, 30, 63, 31, 1, 8'h80);
      add_segment(30, 63, 31, 0, 1, 8'h80);
      add_segment(-1, 32, 64, 32, 1, 8'hFE);
      add_segment(0, 0, 0, 63, 0, 8'h00);
      drain();

      // single-pixel window at one corner, inverted window, single-pixel window at the other corner
      set_window(63, 63, 63, 63);
      add_segment(63, 63, 63, 63, 0, 8'h11);
      add_segment(0, 0, 100, 100, 1, 8'h22);
      add_segment(63, -5, 63, 80, 0, 8'h33);
      drain();
      set_window(40, 10, 0, 63);                    // inverted: all rejected
      add_segment(20, 20, 30, 30, 0, 8'h44);
      add_segment(0, 0, 63, 63, 1, 8'h55);
      drain();
      csr_write(CSR_PALETTE, 64'hFFFF_FFFF_FFFF_FFFF);
      set_window(0, 0, 0, 0);
      add_segment(0, 0, 0, 0, 1, 8'h66);
      add_segment(-3, -3, 3, 3, 1, 8'h66);
      drain();

      // random phases under varied windows
      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 0) set_window(0, 63, 0, 63);
         else set_window($urandom_range(0, 40), $urandom_range(20, 63),
                         $urandom_range(0, 40), $urandom_range(20, 63));
         csr_write(CSR_PALETTE, {$urandom, $urandom});
         if (phase == 2) begin
            // sender pauses while each batch is queued, then resumes; the first batch drains before the second
            feeding = 1'b0;
            random_segments(10);
            @(posedge clock);
            feeding = 1'b1;
            drain();
            feeding = 1'b0;
            random_segments(10);
            @(posedge clock);
            feeding = 1'b1;
         end else if (phase == 3) begin
            random_segments(40);
            @(negedge clock);
            stall_request = 1'b1;                    // block backs up under long stall
         end else begin
            random_segments(50);
         end
         drain();
      end

      $display("ran %0d segments: %0d pixel writes, %0d rejected lines",
               segments_sent, pixels_seen, rejects_seen);
      $display("windows covered reset, single point, inverted and random settings");
      if (mismatches == 0 && pixel_queue.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("mismatches %0d, leftover %0d", mismatches, pixel_queue.size());
         $display("tb: failure");
      end
      $finish;
   end

endmodule
